[rtl/sorted_insert_queue_assert.svh]
// ----------------------------------------------------------------------------
// Sorted insert queue assertion macros
// Shared property forms for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_QUEUE_ASSERT_SVH
`define SORTED_INSERT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/siq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted insert queue package
// Sizes, operation and status codes, and cell control shared by the queue.
// ----------------------------------------------------------------------------
package siq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_REV    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_INSERT,
    CELL_POP,
    CELL_ROT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_REV
  } siq_state_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_t op;
    cnt_t     count;
    cnt_t     limit;
  } cell_ctl_t;

  // Sign-extend or truncate the 32-bit input to the stored width.
  function automatic value_t to_entry(input logic signed [DATA_W-1:0] x);
    return VALUE_BITS'(x);
  endfunction

  // Low 32 bits of a stored entry, zero-extended when the entry is narrower.
  function automatic logic [DATA_W-1:0] from_entry(input value_t e);
    return DATA_W'($unsigned(e));
  endfunction

endpackage

[rtl/siq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted insert queue cell
// One storage slot: compares against the broadcast value and shifts to or
// from its neighbors as the broadcast command directs.
// ----------------------------------------------------------------------------
module siq_cell import siq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  cnt_t      idx,
  input  value_t    bcast,
  input  value_t    left_val,
  input  value_t    right_val,
  input  logic      found_in,
  output logic      found_out,
  output value_t    value_o
);

  value_t               entry_r;
  value_t               entry_nxt;
  logic                 gt;
  logic [CNT_W:0]       idx_p1;

  assign idx_p1  = {1'b0, idx} + (CNT_W + 1)'(1);
  assign value_o = entry_r;

  always_comb begin
    // A live entry strictly greater than the new value marks an insert point.
    gt        = (idx < ctl.count) && (entry_r > bcast);
    found_out = found_in | gt;
    entry_nxt = entry_r;
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_PUSH: begin
        if (idx == ctl.count) begin
          entry_nxt = bcast;
        end
      end
      CELL_INSERT: begin
        if (idx <= ctl.count) begin
          if (found_in) begin
            entry_nxt = left_val;
          end else if (gt || (idx == ctl.count)) begin
            entry_nxt = bcast;
          end
        end
      end
      CELL_POP: begin
        if (idx_p1 < {1'b0, ctl.count}) begin
          entry_nxt = right_val;
        end
      end
      CELL_ROT: begin
        if (idx_p1 < {1'b0, ctl.limit}) begin
          entry_nxt = right_val;
        end else if (idx_p1 == {1'b0, ctl.limit}) begin
          entry_nxt = bcast;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/sorted_insert_queue.sv]
// ----------------------------------------------------------------------------
// Sorted insert queue
// Bounded queue of signed values built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Push, priority insert and pop: the result strobes in the cycle after start,
// and busy stays low, so one transaction per cycle while no reverse runs.
// Reverse of n entries rotates the chain prefix once per length, n down to 2;
// busy is high for all but the first rotation. Empty or single-entry reverse: none.
// Reset (rst_n low, synchronous) empties the queue; cell contents are kept.
// The result is valid for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_insert_queue import siq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_func,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [COUNT_OUT_W-1:0]   out_count_out
);

`include "sorted_insert_queue_assert.svh"

  // Control state.
  siq_state_t state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       lim_r, lim_nxt;

  // Result registers. The strobe is control; the payload needs no reset.
  logic              ovalid_r, ovalid_nxt;
  status_t           ostat_r, ostat_nxt;
  logic [DATA_W-1:0] oval_r, oval_nxt;

  // Chain signals.
  cell_ctl_t ctl;
  value_t    bcast;
  value_t    new_val;
  value_t    cell_val [DEPTH];
  logic      found [DEPTH+1];
  logic      accept;
  func_t     func;

  assign func    = func_t'(in_func);
  assign accept  = start && !busy;
  assign busy    = (state_r == S_REV);
  assign new_val = to_entry(in_value_in);

  // The broadcast bus carries the incoming value for push and insert, and the
  // head entry during a rotation, which drops it in at the end of the prefix.
  assign bcast = (ctl.op == CELL_ROT) ? cell_val[0] : new_val;

  // Reverse is built from prefix rotations: rotating the first k entries left
  // by one for k = n, n-1, ..., 2 leaves the first n entries reversed.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    lim_nxt    = lim_r;
    ovalid_nxt = 1'b0;
    ostat_nxt  = ST_OK;
    oval_nxt   = '0;
    ctl.op     = CELL_HOLD;
    ctl.count  = count_r;
    ctl.limit  = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_PUSH, FUNC_INSERT: begin
              ovalid_nxt = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                // A full queue drops the value.
                ostat_nxt = ST_FULL;
              end else begin
                ctl.op    = (func == FUNC_PUSH) ? CELL_PUSH : CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_POP: begin
              ovalid_nxt = 1'b1;
              if (count_r == '0) begin
                ostat_nxt = ST_EMPTY;
              end else begin
                ctl.op    = CELL_POP;
                oval_nxt  = from_entry(cell_val[0]);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FUNC_REV: begin
              if (count_r < CNT_W'(2)) begin
                // Nothing to reorder.
                ovalid_nxt = 1'b1;
              end else begin
                ctl.op = CELL_ROT;
                if (count_r == CNT_W'(2)) begin
                  ovalid_nxt = 1'b1;
                end else begin
                  lim_nxt   = count_r - CNT_W'(1);
                  state_nxt = S_REV;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REV: begin
        ctl.op    = CELL_ROT;
        ctl.limit = lim_r;
        if (lim_r == CNT_W'(2)) begin
          // Last rotation: report the finished transaction.
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          lim_nxt = lim_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      lim_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      lim_r    <= lim_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oval_r  <= oval_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_status    = ostat_r;
  assign out_value_out = oval_r;
  assign out_count_out = COUNT_OUT_W'(count_r);

  // The chain of cells. Cell 0 is the head. The found flag ripples from the
  // head toward the tail and tells each cell that an insert point lies ahead
  // of it, so it takes its left neighbor's entry.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left_v;
    value_t right_v;
    if (i == 0) begin : g_head
      assign left_v = cell_val[i];
    end else begin : g_body_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = cell_val[i];
    end else begin : g_body_r
      assign right_v = cell_val[i+1];
    end
    siq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (CNT_W'(i)),
      .bcast     (bcast),
      .left_val  (left_v),
      .right_val (right_v),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .value_o   (cell_val[i])
    );
  end

  // The occupancy can never pass the number of cells.
  `SIQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH),
    "occupancy exceeds queue depth")
  // While reversing, the rotation length stays within the live entries.
  `SIQ_ASSERT_IMP(a_rev_limit, state_r == S_REV,
    (lim_r >= CNT_W'(2)) && (lim_r < count_r), "rotation length out of range")
  // Every non-reverse transaction is answered in the very next cycle.
  `SIQ_ASSERT_NXT(a_quick_result, accept && (func != FUNC_REV), ovalid_r,
    "missing result after single-cycle transaction")
  // A pop on an empty queue leaves it empty and returns zero.
  `SIQ_ASSERT_IMP(a_empty_pop, ovalid_r && (ostat_r == ST_EMPTY),
    (count_r == '0) && (oval_r == '0), "empty pop result inconsistent")

endmodule
